// ===== design/chgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_pkg: shared types and constants for the Graham scan hull block
// Sizes of the point store, index and coordinate widths, controller commands.
// ----------------------------------------------------------------------------
package chgs_pkg;
  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int IdxBits   = $clog2(MaxPoints);
  localparam int CntBits   = IdxBits + 1;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int CrossBits = ProdBits + 1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IdxBits-1:0]          idx_t;
  typedef logic [CntBits-1:0]          cnt_t;

  // datapath operations requested by the controller
  localparam logic [3:0] OpNone     = 4'd0;
  localparam logic [3:0] OpLoad     = 4'd1;
  localparam logic [3:0] OpRdPt     = 4'd2;  // read point at addr into slot A/B/C
  localparam logic [3:0] OpRdOrd    = 4'd3;  // read order entry at addr
  localparam logic [3:0] OpWrOrd    = 4'd4;  // write order entry
  localparam logic [3:0] OpRdStk    = 4'd5;  // read stack entry
  localparam logic [3:0] OpWrStk    = 4'd6;  // write stack entry
  localparam logic [3:0] OpMul      = 4'd7;  // form products from slots
  localparam logic [3:0] OpCross    = 4'd8;  // combine products

  typedef struct packed {
    logic [3:0] op;
    idx_t       addr;
    idx_t       wdata;
    logic [1:0] slot;
    logic       use_dist;   // products form squared distance instead of cross
  } dp_cmd_t;

  typedef struct packed {
    idx_t        rdata;   // registered index read
    coord_t      ax;
    coord_t      ay;
    coord_t      bx;
    coord_t      by;
    coord_t      cx;
    coord_t      cy;
    logic signed [CrossBits-1:0] res;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== design/chgs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module chgs_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/chgs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_dp: datapath of the hull block
// Point, order and stack memories, three point slots and a cross/distance unit.
// ----------------------------------------------------------------------------
module chgs_dp (
  input  wire logic             clk,
  input  wire chgs_pkg::dp_cmd_t cmd,
  input  wire chgs_pkg::coord_t  in_x,
  input  wire chgs_pkg::coord_t  in_y,
  output chgs_pkg::dp_stat_t     stat
);
  import chgs_pkg::*;

  logic [2*CoordBits-1:0] pt_rd;
  idx_t ord_rd, stk_rd;
  logic pt_we, ord_we, stk_we;
  logic [3:0] op_q;
  logic [1:0] slot_q;
  coord_t ax, ay, bx, by, cx, cy;
  logic signed [ProdBits-1:0] p0, p1;
  logic signed [CrossBits-1:0] res;
  logic signed [DiffBits-1:0] d0, d1, d2, d3;

  assign pt_we  = (cmd.op == OpLoad);
  assign ord_we = (cmd.op == OpWrOrd);
  assign stk_we = (cmd.op == OpWrStk);

  chgs_ram #(.Width(2*CoordBits), .Depth(MaxPoints)) u_pt (
    .clk(clk), .we(pt_we), .addr(cmd.addr), .wdata({in_x, in_y}), .rdata(pt_rd));
  chgs_ram #(.Width(IdxBits), .Depth(MaxPoints)) u_ord (
    .clk(clk), .we(ord_we), .addr(cmd.addr), .wdata(cmd.wdata), .rdata(ord_rd));
  chgs_ram #(.Width(IdxBits), .Depth(MaxPoints)) u_stk (
    .clk(clk), .we(stk_we), .addr(cmd.addr), .wdata(cmd.wdata), .rdata(stk_rd));

  // differences against slot A; C for cross, B itself for distance
  always_comb begin
    d0 = DiffBits'(bx) - DiffBits'(ax);
    d1 = cmd.use_dist ? d0 : (DiffBits'(cy) - DiffBits'(ay));
    d2 = DiffBits'(cx) - DiffBits'(ax);
    d3 = DiffBits'(by) - DiffBits'(ay);
  end

  // slot capture from the registered RAM read data, using the registered op and slot; products then combine
  always_ff @(posedge clk) begin
    op_q   <= cmd.op;
    slot_q <= cmd.slot;
    if (op_q == OpRdPt) begin
      unique case (slot_q)
        2'd0: begin ax <= coord_t'(pt_rd[2*CoordBits-1:CoordBits]);
          ay <= coord_t'(pt_rd[CoordBits-1:0]); end
        2'd1: begin bx <= coord_t'(pt_rd[2*CoordBits-1:CoordBits]);
          by <= coord_t'(pt_rd[CoordBits-1:0]); end
        default: begin cx <= coord_t'(pt_rd[2*CoordBits-1:CoordBits]);
          cy <= coord_t'(pt_rd[CoordBits-1:0]); end
      endcase
    end
    if (cmd.op == OpMul) begin
      p0 <= d0 * d1;
      p1 <= cmd.use_dist ? d3 * d3 : d2 * d3;
    end
    if (cmd.op == OpCross) begin
      res <= cmd.use_dist ? (CrossBits'(p0) + CrossBits'(p1))
                          : (CrossBits'(p0) - CrossBits'(p1));
    end
  end

  always_comb begin
    stat.rdata = (op_q == OpRdStk) ? stk_rd : ord_rd;
    stat.ax = ax; stat.ay = ay; stat.bx = bx; stat.by = by;
    stat.cx = cx; stat.cy = cy;
    stat.res = res;
  end
endmodule
`default_nettype wire

// ===== design/chgs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chgs_ctrl: controller of the hull block
// Load, anchor search, insertion sort, stack scan and vertex output.
// ----------------------------------------------------------------------------
module chgs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pt_valid,
  output logic                   pt_ready,
  input  wire logic              pt_last,
  output logic                   hull_valid,
  input  wire logic              hull_ready,
  output chgs_pkg::coord_t       hull_x,
  output chgs_pkg::coord_t       hull_y,
  output logic                   hull_last,
  output chgs_pkg::dp_cmd_t      cmd,
  input  wire chgs_pkg::dp_stat_t stat
);
  import chgs_pkg::*;

  // state codes
  localparam logic [4:0] SLoad   = 5'd0;
  localparam logic [4:0] SAnRd   = 5'd1;
  localparam logic [4:0] SAnWt   = 5'd2;
  localparam logic [4:0] SAnCmp  = 5'd3;
  localparam logic [4:0] SOrdWr  = 5'd4;
  localparam logic [4:0] SSrtRdV = 5'd5;
  localparam logic [4:0] SSrtWtV = 5'd6;
  localparam logic [4:0] SSrtRdJ = 5'd7;
  localparam logic [4:0] SSrtWtJ = 5'd8;
  localparam logic [4:0] SSrtPtQ = 5'd9;
  localparam logic [4:0] SSrtWtQ = 5'd10;
  localparam logic [4:0] SCmp    = 5'd11;
  localparam logic [4:0] SCmpW   = 5'd12;
  localparam logic [4:0] SCmpR   = 5'd13;
  localparam logic [4:0] SScRdP  = 5'd14;
  localparam logic [4:0] SScWtP  = 5'd15;
  localparam logic [4:0] SScPtC  = 5'd16;
  localparam logic [4:0] SScWtC  = 5'd17;
  localparam logic [4:0] SScRdT  = 5'd18;
  localparam logic [4:0] SScWtT  = 5'd19;
  localparam logic [4:0] SScPtT  = 5'd20;
  localparam logic [4:0] SScWtT2 = 5'd21;
  localparam logic [4:0] SScTurn = 5'd22;
  localparam logic [4:0] SOutRd  = 5'd23;
  localparam logic [4:0] SOutWt  = 5'd24;
  localparam logic [4:0] SOutPt  = 5'd25;
  localparam logic [4:0] SOutWt2 = 5'd26;
  localparam logic [4:0] SOut    = 5'd27;
  localparam logic [4:0] SMul    = 5'd28;
  localparam logic [4:0] SCross  = 5'd29;
  localparam logic [4:0] SCrWt   = 5'd30;

  logic [4:0] state, state_next, ret, ret_next;
  cnt_t count, count_next, i, i_next, j, j_next, top, top_next;
  idx_t anchor, anchor_next, v, v_next, q, q_next, p, p_next;
  idx_t s1, s1_next;
  logic use_dist, use_dist_next;
  logic [2:0] phase, phase_next;
  logic signed [CrossBits-1:0] cr, cr_next;
  coord_t ox, ox_next, oy, oy_next;
  logic olast, olast_next, ovalid, ovalid_next;
  logic fire;
  logic dup;

  assign fire = pt_valid && pt_ready;
  assign pt_ready = (state == SLoad);
  assign hull_valid = ovalid;
  assign hull_x = ox;
  assign hull_y = oy;
  assign hull_last = olast;
  assign dup = (stat.bx == stat.cx) && (stat.by == stat.cy);

  always_comb begin
    state_next = state; ret_next = ret; count_next = count; i_next = i; j_next = j;
    top_next = top; anchor_next = anchor; v_next = v; q_next = q; p_next = p;
    s1_next = s1; use_dist_next = use_dist; phase_next = phase; cr_next = cr;
    ox_next = ox; oy_next = oy; olast_next = olast; ovalid_next = ovalid;
    cmd = '0;
    if (ovalid && hull_ready) ovalid_next = 1'b0;
    unique case (state)
      // one beat per point into the point store
      SLoad: begin
        if (fire) begin
          cmd.op = OpLoad; cmd.addr = count[IdxBits-1:0];
          count_next = count + 1'b1;
          if (pt_last || count == cnt_t'(MaxPoints - 1)) begin
            anchor_next = '0; i_next = cnt_t'(1);
            cmd.op = OpLoad;
            state_next = SAnRd; phase_next = '0;
          end
        end
      end
      // anchor search: A holds anchor, B holds candidate
      SAnRd: begin
        if (i >= count) begin
          i_next = '0; j_next = cnt_t'(1); state_next = SOrdWr;
          cmd.op = OpWrOrd; cmd.addr = '0; cmd.wdata = anchor;
        end else begin
          cmd.op = OpRdPt;
          cmd.addr = phase[0] ? i[IdxBits-1:0] : anchor;
          cmd.slot = phase[0] ? 2'd1 : 2'd0;
          state_next = SAnWt;
        end
      end
      SAnWt: begin
        if (!phase[0]) begin phase_next = 3'd1; state_next = SAnRd; end
        else state_next = SAnCmp;
      end
      SAnCmp: begin
        phase_next = '0;
        if (stat.bx < stat.ax || (stat.bx == stat.ax && stat.by < stat.ay))
          anchor_next = i[IdxBits-1:0];
        i_next = i + 1'b1; state_next = SAnRd;
      end
      // order list: anchor then the rest in arrival order
      SOrdWr: begin
        if (i >= count) begin
          i_next = cnt_t'(2); state_next = SSrtRdV;
        end else begin
          if (i[IdxBits-1:0] != anchor) begin
            cmd.op = OpWrOrd; cmd.addr = j[IdxBits-1:0];
            cmd.wdata = i[IdxBits-1:0]; j_next = j + 1'b1;
          end
          i_next = i + 1'b1;
        end
      end
      // insertion sort, outer step
      SSrtRdV: begin
        if (i >= count) begin
          top_next = '0; s1_next = anchor; i_next = cnt_t'(1);
          cmd.op = OpWrStk; cmd.addr = '0; cmd.wdata = anchor;
          state_next = SScRdP;
        end else begin
          cmd.op = OpRdOrd; cmd.addr = i[IdxBits-1:0]; state_next = SSrtWtV;
        end
      end
      SSrtWtV: begin v_next = stat.rdata; j_next = i; state_next = SSrtRdJ; end
      SSrtRdJ: begin
        if (j <= cnt_t'(1)) begin
          cmd.op = OpWrOrd; cmd.addr = j[IdxBits-1:0]; cmd.wdata = v;
          i_next = i + 1'b1; state_next = SSrtRdV;
        end else begin
          cmd.op = OpRdOrd; cmd.addr = IdxBits'(j - 1'b1); state_next = SSrtWtJ;
        end
      end
      SSrtWtJ: begin q_next = stat.rdata; phase_next = '0; state_next = SSrtPtQ; end
      // load anchor (A), v (B), q (C)
      SSrtPtQ: begin
        cmd.op = OpRdPt; cmd.slot = phase[1:0];
        unique case (phase[1:0])
          2'd0: cmd.addr = anchor;
          2'd1: cmd.addr = v;
          default: cmd.addr = q;
        endcase
        state_next = SSrtWtQ;
      end
      SSrtWtQ: begin
        if (phase == 3'd2) begin
          use_dist_next = 1'b0; ret_next = SCmp; state_next = SMul;
        end else begin
          phase_next = phase + 1'b1; state_next = SSrtPtQ;
        end
      end
      SCmp: begin
        // cross done: nonzero decides, zero needs distances
        if (cr != '0) begin
          state_next = SCmpR; phase_next = {2'b0, cr[CrossBits-1]};
        end else begin
          // dist(v) into cr via B; then compare with dist(q)
          use_dist_next = 1'b1; ret_next = SCmpW; state_next = SMul;
        end
      end
      SCmpW: begin
        // cr now holds dist(a,v); swap q into B to get dist(a,q)
        s1_next = idx_t'(0);
        cmd.op = OpRdPt; cmd.addr = q; cmd.slot = 2'd1;
        p_next = '0; state_next = SCmpR; phase_next = 3'd4;
      end
      SCmpR: begin
        if (phase == 3'd4) begin
          phase_next = 3'd5; // wait for slot B load
        end else if (phase == 3'd5) begin
          phase_next = 3'd6; ret_next = SCmpR; use_dist_next = 1'b1;
          v_next = v; state_next = SMul;
          q_next = q;
          // keep dist(v) aside in ox/oy is not possible; use top bits below
        end else begin
          // phase 6: stat.res holds dist(q), cr still holds dist(v); decision bit in phase[0]
          if (phase == 3'd6) phase_next = {2'b0, ($signed(stat.res) > cr)};
          if ((phase == 3'd6) ? ($signed(stat.res) > cr) : phase[0]) begin
            cmd.op = OpWrOrd; cmd.addr = j[IdxBits-1:0]; cmd.wdata = q;
            j_next = j - 1'b1; state_next = SSrtRdJ;
          end else begin
            cmd.op = OpWrOrd; cmd.addr = j[IdxBits-1:0]; cmd.wdata = v;
            i_next = i + 1'b1; state_next = SSrtRdV;
          end
        end
      end
      // scan: read order[i], compare against stack top
      SScRdP: begin
        if (i >= count) begin
          i_next = '0; state_next = SOutRd;
        end else begin
          cmd.op = OpRdOrd; cmd.addr = i[IdxBits-1:0]; state_next = SScWtP;
        end
      end
      SScWtP: begin p_next = stat.rdata; phase_next = '0; state_next = SScPtC; end
      SScPtC: begin
        cmd.op = OpRdPt; cmd.slot = phase[0] ? 2'd1 : 2'd2;
        cmd.addr = phase[0] ? s1 : p; state_next = SScWtC;
      end
      // phase 1 takes an extra wait step in this state so slot B has landed before the compare
      SScWtC: begin
        if (phase == 3'd0) begin phase_next = 3'd1; state_next = SScPtC; end
        else if (phase == 3'd1) phase_next = 3'd2;
        else if (dup) begin i_next = i + 1'b1; state_next = SScRdP; end
        else state_next = SScRdT;
      end
      SScRdT: begin
        if (top == '0) begin
          top_next = top + 1'b1; s1_next = p;
          cmd.op = OpWrStk; cmd.addr = IdxBits'(top + 1'b1); cmd.wdata = p;
          i_next = i + 1'b1; state_next = SScRdP;
        end else begin
          cmd.op = OpRdStk; cmd.addr = IdxBits'(top - 1'b1); state_next = SScWtT;
        end
      end
      SScWtT: begin q_next = stat.rdata; state_next = SScPtT; end
      SScPtT: begin
        cmd.op = OpRdPt; cmd.slot = 2'd0; cmd.addr = q; state_next = SScWtT2;
      end
      SScWtT2: begin use_dist_next = 1'b0; ret_next = SScTurn; state_next = SMul; end
      SScTurn: begin
        if (!cr[CrossBits-1]) begin
          // pop: new top is q, already in A; move to B
          top_next = top - 1'b1; s1_next = q;
          cmd.op = OpRdPt; cmd.slot = 2'd1; cmd.addr = q;
          phase_next = 3'd1; state_next = SScWtC;
        end else begin
          top_next = top + 1'b1; s1_next = p;
          cmd.op = OpWrStk; cmd.addr = IdxBits'(top + 1'b1); cmd.wdata = p;
          i_next = i + 1'b1; state_next = SScRdP;
        end
      end
      // shared multiply and combine, returns to ret
      SMul: begin cmd.op = OpMul; cmd.use_dist = use_dist; state_next = SCross; end
      SCross: begin cmd.op = OpCross; cmd.use_dist = use_dist; state_next = SCrWt; end
      SCrWt: begin
        if (ret != SCmpR) cr_next = stat.res;
        state_next = ret;
      end
      // output vertices from the stack
      SOutRd: begin
        if (!ovalid || hull_ready) begin
          cmd.op = OpRdStk; cmd.addr = i[IdxBits-1:0]; state_next = SOutWt;
        end
      end
      SOutWt: begin q_next = stat.rdata; state_next = SOutPt; end
      SOutPt: begin
        cmd.op = OpRdPt; cmd.slot = 2'd0; cmd.addr = q; state_next = SOutWt2;
      end
      SOutWt2: state_next = SOut;
      SOut: begin
        if (!ovalid || hull_ready) begin
          ovalid_next = 1'b1; ox_next = stat.ax; oy_next = stat.ay;
          olast_next = (i == top);
          if (i == top) begin count_next = '0; state_next = SLoad; end
          else begin i_next = i + 1'b1; state_next = SOutRd; end
        end
      end
      default: state_next = SLoad;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SLoad; count <= '0; top <= '0; ovalid <= 1'b0;
    end else begin
      state <= state_next; count <= count_next; top <= top_next; ovalid <= ovalid_next;
    end
    ret <= ret_next; i <= i_next; j <= j_next; anchor <= anchor_next;
    v <= v_next; q <= q_next; p <= p_next; s1 <= s1_next; use_dist <= use_dist_next;
    phase <= phase_next; cr <= cr_next; ox <= ox_next; oy <= oy_next;
    olast <= olast_next;
  end

  // input beats are taken only while loading
  a_load_only: assert property (@(posedge clk) disable iff (rst)
    fire |-> (state == SLoad)) else $error("input taken outside load");
  // a waiting vertex holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !hull_ready |=> ovalid && $stable(ox) && $stable(oy))
    else $error("vertex changed while stalled");
  // stack never exceeds the point store depth MaxPoints
  a_top: assert property (@(posedge clk) disable iff (rst)
    top <= cnt_t'(MaxPoints)) else $error("stack overflow");
endmodule
`default_nettype wire

// ===== design/convex_hull_graham_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// convex_hull_graham_scan: convex hull of a point set by Graham scan
// Controller plus datapath; points load one beat per cycle, hull follows.
// ----------------------------------------------------------------------------
// Input is held off while a hull is built.
// After the last point come the anchor search, the insertion sort (with a distance
// compare when a point is collinear with the anchor, n*n/2 compares worst case)
// and the stack scan with its pops, all paced by the single point-store read port.
// Hull vertices then go out as the receiver takes them; the next set may load while
// the last vertex waits. Reset clears the point count and drops output.
module convex_hull_graham_scan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pt_valid,
  output logic                   pt_ready,
  input  wire chgs_pkg::coord_t  pt_x,
  input  wire chgs_pkg::coord_t  pt_y,
  input  wire logic              pt_last,
  output logic                   hull_valid,
  input  wire logic              hull_ready,
  output chgs_pkg::coord_t       hull_x,
  output chgs_pkg::coord_t       hull_y,
  output logic                   hull_last
);
  import chgs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  chgs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .pt_valid(pt_valid), .pt_ready(pt_ready),
    .pt_last(pt_last), .hull_valid(hull_valid),
    .hull_ready(hull_ready), .hull_x(hull_x), .hull_y(hull_y),
    .hull_last(hull_last), .cmd(cmd), .stat(stat));

  chgs_dp u_dp (
    .clk(clk), .cmd(cmd), .in_x(pt_x), .in_y(pt_y), .stat(stat));
endmodule
`default_nettype wire
